// File: rtl/core/spq_pkg.sv
// Shared types and constants for the stable priority queue.
package spq_pkg;

	// Width of an entry priority
	localparam int unsigned PRIO_W = 3;

	// Width of the stream identifier fields
	localparam int unsigned IO_ID_W = 16;

	// Width of the reported occupancy
	localparam int unsigned OCC_W = 5;

	// Operation codes carried in s_tuser
	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	// Result status carried in m_tuser
	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_FULL     = 2'd1,
		ST_DEQUEUED = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// Operation broadcast to every cell of the chain
	typedef struct packed {
		logic              enq;
		logic              deq;
		logic [PRIO_W-1:0] prio;
	} cell_ctrl_t;

endpackage

// File: rtl/core/spq_cell.sv
// One cell of the sorted shift chain: holds a single entry and shifts with its neighbors.
module spq_cell
	import spq_pkg::*;
#(
	parameter int unsigned ID_WIDTH = 16
) (
	input  logic                clk,
	input  cell_ctrl_t          ctrl,
	input  logic [ID_WIDTH-1:0] new_id,
	input  logic                valid,
	input  logic                left_gt,
	input  logic [ID_WIDTH-1:0] left_id,
	input  logic [PRIO_W-1:0]   left_prio,
	input  logic [ID_WIDTH-1:0] right_id,
	input  logic [PRIO_W-1:0]   right_prio,
	output logic [ID_WIDTH-1:0] id_q,
	output logic [PRIO_W-1:0]   prio_q,
	output logic                gt
);

	// New entry goes in front of this cell: empty slot or strictly larger priority
	assign gt = !valid || (prio_q > ctrl.prio);

	// Insert shifts right from the insertion point; dequeue shifts left
	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (gt && left_gt) begin
				id_q   <= left_id;
				prio_q <= left_prio;
			end else if (gt) begin
				id_q   <= new_id;
				prio_q <= ctrl.prio;
			end
		end else if (ctrl.deq) begin
			id_q   <= right_id;
			prio_q <= right_prio;
		end
	end

endmodule

// File: rtl/core/stable_priority_queue.sv
// Stable priority queue built as a sorted shift chain of entry cells.
// Each transaction on the slave side is an enqueue (s_tuser = 0) or a dequeue (s_tuser = 1) and
// yields exactly one result transaction on the master side, registered in the output register when
// accepted. The queue takes one transaction per cycle: every cell compares its priority with the
// incoming one in parallel and shifts in the same cycle, so the rate is set only by the output
// register, which is refilled whenever its result is taken. Smaller priority values leave first
// and equal priorities leave in arrival order. An enqueue into a full queue is dropped with
// status full; a dequeue from an empty queue reports status empty. Identifier and priority read
// as zero except on a successful dequeue; occupancy is the entry count after the transaction.
module stable_priority_queue
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH    = 16,
	parameter int unsigned ID_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // item_id[15:0], item_priority[18:16], zero fill
	input  logic [0:0]  s_tuser,  // mode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // out_id[15:0], out_priority[18:16], occupancy[23:19]
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic                accept;
	logic                mode;
	logic [IO_ID_W-1:0]  item_id;
	logic [PRIO_W-1:0]   item_priority;
	logic                is_full;
	logic                is_empty;
	cell_ctrl_t          ctrl;
	logic [ID_WIDTH+IO_ID_W-1:0] id_in_ext;
	logic [ID_WIDTH-1:0] new_id;
	logic [ID_WIDTH+IO_ID_W-1:0] id_out_ext;
	logic [CNT_W+OCC_W-1:0]      occ_ext;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_next;
	status_t             status_next;

	logic                out_valid_q;
	status_t             status_q;
	logic [IO_ID_W-1:0]  out_id_q;
	logic [PRIO_W-1:0]   out_prio_q;
	logic [OCC_W-1:0]    occ_q;

	logic [ID_WIDTH-1:0] cell_id   [DEPTH];
	logic [PRIO_W-1:0]   cell_prio [DEPTH];
	logic                cell_gt   [DEPTH];

	// Input unpacking and handshake
	assign mode          = s_tuser[0];
	assign item_id       = s_tdata[IO_ID_W-1:0];
	assign item_priority = s_tdata[IO_ID_W+PRIO_W-1:IO_ID_W];
	assign s_tready      = !out_valid_q || m_tready;
	assign accept        = s_tvalid && s_tready;

	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);

	// Resize identifier into cell storage width
	assign id_in_ext = {{ID_WIDTH{1'b0}}, item_id};
	assign new_id    = id_in_ext[ID_WIDTH-1:0];

	// Broadcast operation; rejected operations leave the chain alone
	always_comb begin
		ctrl.enq  = accept && (mode == MODE_ENQ) && !is_full;
		ctrl.deq  = accept && (mode == MODE_DEQ) && !is_empty;
		ctrl.prio = item_priority;
	end

	// Cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                lgt;
		logic [ID_WIDTH-1:0] lid;
		logic [PRIO_W-1:0]   lprio;
		logic [ID_WIDTH-1:0] rid;
		logic [PRIO_W-1:0]   rprio;

		if (i == 0) begin : g_first
			assign lgt   = 1'b0;
			assign lid   = new_id;
			assign lprio = item_priority;
		end else begin : g_mid
			assign lgt   = cell_gt[i-1];
			assign lid   = cell_id[i-1];
			assign lprio = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rid   = cell_id[i];
			assign rprio = cell_prio[i];
		end else begin : g_inner
			assign rid   = cell_id[i+1];
			assign rprio = cell_prio[i+1];
		end

		spq_cell #(
			.ID_WIDTH(ID_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.new_id    (new_id),
			.valid     (count_q > CNT_W'(i)),
			.left_gt   (lgt),
			.left_id   (lid),
			.left_prio (lprio),
			.right_id  (rid),
			.right_prio(rprio),
			.id_q      (cell_id[i]),
			.prio_q    (cell_prio[i]),
			.gt        (cell_gt[i])
		);
	end

	// Status and next occupancy
	always_comb begin
		count_next  = count_q;
		status_next = ST_ENQUEUED;
		if (mode == MODE_ENQ) begin
			if (is_full) begin
				status_next = ST_FULL;
			end else begin
				status_next = ST_ENQUEUED;
				count_next  = count_q + CNT_W'(1);
			end
		end else begin
			if (is_empty) begin
				status_next = ST_EMPTY;
			end else begin
				status_next = ST_DEQUEUED;
				count_next  = count_q - CNT_W'(1);
			end
		end
	end

	// Resize head identifier and occupancy to the stream field widths
	assign id_out_ext = {{IO_ID_W{1'b0}}, cell_id[0]};
	assign occ_ext    = {{OCC_W{1'b0}}, count_next};

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_next;
			occ_q    <= occ_ext[OCC_W-1:0];
			if (status_next == ST_DEQUEUED) begin
				out_id_q   <= id_out_ext[IO_ID_W-1:0];
				out_prio_q <= cell_prio[0];
			end else begin
				out_id_q   <= '0;
				out_prio_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {occ_q, out_prio_q, out_id_q};
	assign m_tuser  = status_q;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the stable priority queue: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_top
	import spq_pkg::*;
;

	localparam int unsigned DEPTH        = 16;
	localparam int unsigned RANDOM_ITEMS = 400;
	localparam int unsigned TAIL_ITEMS   = 60;
	localparam int unsigned HOLD_CYCLES  = 40;
	localparam int unsigned STALL_LIMIT  = 500;

	// One result transaction as seen on the master side
	typedef struct packed {
		logic [1:0]         st;
		logic [IO_ID_W-1:0] oid;
		logic [PRIO_W-1:0]  oprio;
		logic [OCC_W-1:0]   occ;
	} result_t;

	// One row of the directed stimulus table
	typedef struct {
		logic               mode;
		logic [IO_ID_W-1:0] id;
		logic [PRIO_W-1:0]  prio;
		bit                 typed;
		result_t            res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // item_id[15:0], item_priority[18:16], zero fill
	logic [0:0]  s_tuser;   // mode[0]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // out_id[15:0], out_priority[18:16], occupancy[23:19]
	logic [1:0]  m_tuser;   // status[1:0]

	stable_priority_queue #(
		.DEPTH   (DEPTH),
		.ID_WIDTH(IO_ID_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// Predicted queue contents, kept sorted, head at index 0
	logic [IO_ID_W-1:0] held_id[DEPTH];
	logic [PRIO_W-1:0]  held_prio[DEPTH];
	int unsigned        held_count;

	result_t  expected_results[$];
	dir_row_t directed_rows[$];

	int unsigned errors;
	int unsigned n_enq, n_full, n_deq, n_empty;
	int unsigned results_checked;
	int unsigned stall_cycles;
	bit          tail_phase;
	bit          hold_done;

	// Clock: 8 ns period
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Sorted insert behind equal priorities, head removal on dequeue
	function automatic result_t predict_queue(input logic mode, input logic [IO_ID_W-1:0] id,
			input logic [PRIO_W-1:0] prio);
		result_t     r;
		int unsigned pos;
		int unsigned i;
		r = '0;
		if (mode == MODE_ENQ) begin
			if (held_count >= DEPTH) begin
				r.st = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && held_prio[pos] <= prio)
					pos++;
				for (i = held_count; i > pos; i--) begin
					held_id[i]   = held_id[i-1];
					held_prio[i] = held_prio[i-1];
				end
				held_id[pos]   = id;
				held_prio[pos] = prio;
				held_count++;
				r.st = ST_ENQUEUED;
			end
		end else begin
			if (held_count == 0) begin
				r.st = ST_EMPTY;
			end else begin
				r.oid   = held_id[0];
				r.oprio = held_prio[0];
				for (i = 0; i + 1 < held_count; i++) begin
					held_id[i]   = held_id[i+1];
					held_prio[i] = held_prio[i+1];
				end
				held_count--;
				r.st = ST_DEQUEUED;
			end
		end
		r.occ = held_count[OCC_W-1:0];
		return r;
	endfunction

	function automatic void add_row(input logic mode, input logic [IO_ID_W-1:0] id,
			input logic [PRIO_W-1:0] prio, input bit typed, input result_t res);
		dir_row_t row;
		row.mode  = mode;
		row.id    = id;
		row.prio  = prio;
		row.typed = typed;
		row.res   = res;
		directed_rows.push_back(row);
	endfunction

	// Offer one transaction, wait for acceptance, queue up its expected result
	task automatic send_item(input logic mode, input logic [IO_ID_W-1:0] id,
			input logic [PRIO_W-1:0] prio, input bit typed, input result_t typed_res);
		result_t     r;
		int unsigned gap;
		gap = 0;
		if (!tail_phase && $urandom_range(0, 9) < 3)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {5'd0, prio, id};
		do @(posedge clk); while (!s_tready);
		r = predict_queue(mode, id, prio);
		expected_results.push_back(typed ? typed_res : r);
	endtask

	// Receiver: random ready bursts, one long hold-off to back up the queue
	initial begin : sink_drive
		m_tready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!tail_phase && !hold_done && results_checked >= 80) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_done = 1'b1;
			end else if (!tail_phase && $urandom_range(0, 9) < 3) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.st    = m_tuser;
			got.oid   = m_tdata[15:0];
			got.oprio = m_tdata[18:16];
			got.occ   = m_tdata[23:19];
			results_checked++;
			case (got.st)
				ST_ENQUEUED: n_enq++;
				ST_FULL:     n_full++;
				ST_DEQUEUED: n_deq++;
				default:     n_empty++;
			endcase
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: status %0d id %h prio %0d occ %0d",
					$time, got.st, got.oid, got.oprio, got.occ);
			end else begin
				want = expected_results.pop_front();
				if (got.st !== want.st || got.oid !== want.oid ||
						got.oprio !== want.oprio || got.occ !== want.occ) begin
					errors++;
					$display({"%0t: mismatch: expected status %0d id %h prio %0d occ %0d,",
						" got status %0d id %h prio %0d occ %0d"},
						$time, want.st, want.oid, want.oprio, want.occ,
						got.st, got.oid, got.oprio, got.occ);
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: watchdog expired, %0d results outstanding",
					$time, expected_results.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin : stimulus
		result_t     none;
		result_t     t;
		int unsigned enq_pct;
		int unsigned prio_span;
		logic        mode;
		none = '0;
		errors = 0;
		n_enq = 0;
		n_full = 0;
		n_deq = 0;
		n_empty = 0;
		results_checked = 0;
		stall_cycles = 0;
		tail_phase = 1'b0;
		held_count = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = MODE_ENQ;

		// Directed table: empty dequeue, extremes, stable fill, full reject
		t = '{st: ST_EMPTY, oid: '0, oprio: '0, occ: 5'd0};
		add_row(MODE_DEQ, 16'h5A5A, 3'd5, 1'b1, t);
		t = '{st: ST_ENQUEUED, oid: '0, oprio: '0, occ: 5'd1};
		add_row(MODE_ENQ, 16'hFFFF, 3'd7, 1'b1, t);
		t = '{st: ST_ENQUEUED, oid: '0, oprio: '0, occ: 5'd2};
		add_row(MODE_ENQ, 16'h0000, 3'd0, 1'b1, t);
		t = '{st: ST_DEQUEUED, oid: 16'h0000, oprio: 3'd0, occ: 5'd1};
		add_row(MODE_DEQ, 16'hFFFF, 3'd7, 1'b1, t);
		t = '{st: ST_DEQUEUED, oid: 16'hFFFF, oprio: 3'd7, occ: 5'd0};
		add_row(MODE_DEQ, 16'h0000, 3'd0, 1'b1, t);
		t = '{st: ST_EMPTY, oid: '0, oprio: '0, occ: 5'd0};
		add_row(MODE_DEQ, 16'hFFFF, 3'd7, 1'b1, t);
		// equal priorities first, then a spread, to fill every cell
		for (int i = 0; i < DEPTH; i++)
			add_row(MODE_ENQ, 16'(16'h1000 + i), (i < 8) ? 3'd3 : 3'((i * 5) % 8),
				1'b0, none);
		t = '{st: ST_FULL, oid: '0, oprio: '0, occ: 5'd16};
		add_row(MODE_ENQ, 16'hA5A5, 3'd0, 1'b1, t);
		add_row(MODE_DEQ, 16'h0000, 3'd0, 1'b0, none);
		add_row(MODE_DEQ, 16'h0000, 3'd0, 1'b0, none);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].mode, directed_rows[i].id, directed_rows[i].prio,
				directed_rows[i].typed, directed_rows[i].res);

		// Random phases biased toward filling, mixing or draining
		enq_pct = 85;
		prio_span = 7;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0:       enq_pct = 85;
					1:       enq_pct = 50;
					default: enq_pct = 15;
				endcase
				// narrow priority range stresses arrival order among equals
				prio_span = ($urandom_range(0, 2) == 0) ? 1 : 7;
			end
			if (n >= RANDOM_ITEMS - TAIL_ITEMS)
				tail_phase = 1'b1;
			mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
			send_item(mode, 16'($urandom), 3'($urandom_range(0, prio_span)), 1'b0, none);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		// Drain, then let the output register settle
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("run covered %0d results: %0d enqueued, %0d rejected full, %0d dequeued",
			results_checked, n_enq, n_full, n_deq);
		$display("and %0d empty, with random stalls on both sides and one long receiver hold-off",
			n_empty);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
